/* rtl/mpfb_pkg.sv */
// Shared constants, request codes and address helpers for the page frame store blitter.
`timescale 1ns / 1ps
package mpfb_pkg;

  localparam int PAGE_COUNT   = 8;
  localparam int COLUMN_COUNT = 128;
  localparam int ROW_COUNT    = PAGE_COUNT * 8;
  localparam int STORE_SIZE   = PAGE_COUNT * COLUMN_COUNT;
  localparam int ADDR_W       = $clog2(STORE_SIZE);

  localparam logic [7:0] BYTE_CLEAR = 8'h00;
  localparam logic [7:0] BYTE_FILL  = 8'hff;

  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic [2:0] {
    REQ_POINT      = 3'd0,
    REQ_BLIT_START = 3'd1,
    REQ_BLIT_BYTE  = 3'd2,
    REQ_CLEAR      = 3'd3,
    REQ_FILL       = 3'd4,
    REQ_READ       = 3'd5
  } req_e;

  function automatic logic on_screen(input logic [7:0] x, input logic [7:0] y);
    return (32'(x) < COLUMN_COUNT) && (32'(y) < ROW_COUNT);
  endfunction

  function automatic addr_t pix_addr(input logic [7:0] x, input logic [7:0] y);
    return ADDR_W'(32'(y[7:3]) * COLUMN_COUNT + 32'(x));
  endfunction

  function automatic addr_t byte_addr(input logic [2:0] page, input logic [6:0] col);
    return ADDR_W'(32'(page) * COLUMN_COUNT + 32'(col));
  endfunction

endpackage

/* rtl/mono_page_framebuffer_blitter.sv */
// Page-organized monochrome frame store with point writes, column blits, clear, fill and read.
// A read item passes through the store's registered read port and S_RD_WAIT into registered read_data_o;
// a point reads in S_IDLE and writes in S_PT_WR, and an off-screen point writes nothing. A blit byte
// uses S_BLIT_RD per store byte touched or off-screen pixel and S_BLIT_WR per on-screen pixel.
// Clear and fill sweep the store of STORE_SIZE (1024) bytes, one byte a cycle; no item is taken meanwhile.
// Reset: async active low; the store is then cleared before an item is taken.
`timescale 1ns / 1ps
module mono_page_framebuffer_blitter (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] req_type_i,
  input  logic [7:0] x_pos_i,
  input  logic [7:0] y_pos_i,
  input  logic       draw_mode_i,
  input  logic [7:0] glyph_height_i,
  input  logic [7:0] pixel_byte_i,
  input  logic       last_byte_i,
  input  logic [2:0] read_page_i,
  input  logic [6:0] read_column_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_data_o
);
  import mpfb_pkg::*;

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_PT_WR,
    S_RD_WAIT,
    S_BLIT_RD,
    S_BLIT_WR
  } state_e;

  state_e     state_q, state_d;
  addr_t      sweep_addr_q, sweep_addr_d;
  logic [7:0] sweep_val_q, sweep_val_d;
  logic [7:0] cx_q, cx_d, cy_q, cy_d, oy_q, oy_d, height_q, height_d;
  logic       pol_q, pol_d, active_q, active_d;
  logic [7:0] data_q, data_d;
  logic [2:0] bitcnt_q, bitcnt_d;
  logic       last_q, last_d;
  logic       mode_q, mode_d;
  logic [2:0] bitsel_q, bitsel_d;
  addr_t      paddr_q, paddr_d;
  logic [7:0] buf_q, buf_d;
  logic       use_mem_q, use_mem_d;
  logic       rd_zero_q, rd_zero_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] read_data_q, read_data_d;

  logic       ram_we;
  addr_t      ram_waddr, ram_raddr;
  logic [7:0] ram_wdata, ram_rdata;

  logic       in_acc;
  req_e       req;
  logic [7:0] ny;
  logic       wrap, step_done;
  logic [7:0] cx_nx, cy_nx;
  logic       pix_on;
  logic [7:0] base, merged, mask;

  mpfb_ram #(
    .WIDTH(8),
    .DEPTH(STORE_SIZE)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign req        = req_e'(req_type_i);
  assign in_stall_o = (state_q != S_IDLE) || ((req == REQ_READ) && out_valid_q);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign ny        = cy_q + 8'd1;
  assign wrap      = (ny >= oy_q) && ((ny - oy_q) == height_q);
  assign cx_nx     = wrap ? cx_q + 8'd1 : cx_q;
  assign cy_nx     = wrap ? oy_q : ny;
  assign step_done = wrap || (bitcnt_q == 3'd7);
  assign pix_on    = data_q[7] ? pol_q : !pol_q;
  assign mask      = 8'd1 << cy_q[2:0];
  assign base      = use_mem_q ? ram_rdata : buf_q;
  assign merged    = pix_on ? (base | mask) : (base & ~mask);

  always_comb begin
    state_d      = state_q;
    sweep_addr_d = sweep_addr_q;
    sweep_val_d  = sweep_val_q;
    cx_d         = cx_q;
    cy_d         = cy_q;
    oy_d         = oy_q;
    height_d     = height_q;
    pol_d        = pol_q;
    active_d     = active_q;
    data_d       = data_q;
    bitcnt_d     = bitcnt_q;
    last_d       = last_q;
    mode_d       = mode_q;
    bitsel_d     = bitsel_q;
    paddr_d      = paddr_q;
    buf_d        = buf_q;
    use_mem_d    = use_mem_q;
    rd_zero_d    = rd_zero_q;
    out_valid_d  = out_valid_q && out_stall_i;
    read_data_d  = read_data_q;
    ram_we       = 1'b0;
    ram_waddr    = paddr_q;
    ram_wdata    = merged;
    ram_raddr    = paddr_q;

    case (state_q)
      S_SWEEP: begin
        ram_we       = 1'b1;
        ram_waddr    = sweep_addr_q;
        ram_wdata    = sweep_val_q;
        sweep_addr_d = sweep_addr_q + addr_t'(1);
        if (sweep_addr_q == addr_t'(STORE_SIZE - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          case (req)
            REQ_POINT: begin
              ram_raddr = pix_addr(x_pos_i, y_pos_i);
              paddr_d   = pix_addr(x_pos_i, y_pos_i);
              mode_d    = draw_mode_i;
              bitsel_d  = y_pos_i[2:0];
              if (on_screen(x_pos_i, y_pos_i)) begin
                state_d = S_PT_WR;
              end
            end
            REQ_BLIT_START: begin
              if (on_screen(x_pos_i, y_pos_i)) begin
                cx_d     = x_pos_i;
                cy_d     = y_pos_i;
                oy_d     = y_pos_i;
                height_d = glyph_height_i;
                pol_d    = draw_mode_i;
                active_d = 1'b1;
              end else begin
                active_d = 1'b0;
              end
            end
            REQ_BLIT_BYTE: begin
              if (active_q) begin
                data_d   = pixel_byte_i;
                last_d   = last_byte_i;
                bitcnt_d = 3'd0;
                state_d  = S_BLIT_RD;
              end
            end
            REQ_CLEAR: begin
              sweep_addr_d = '0;
              sweep_val_d  = BYTE_CLEAR;
              state_d      = S_SWEEP;
            end
            REQ_FILL: begin
              sweep_addr_d = '0;
              sweep_val_d  = BYTE_FILL;
              state_d      = S_SWEEP;
            end
            REQ_READ: begin
              ram_raddr = byte_addr(read_page_i, read_column_i);
              rd_zero_d = !((32'(read_page_i) < PAGE_COUNT) &&
                            (32'(read_column_i) < COLUMN_COUNT));
              state_d   = S_RD_WAIT;
            end
            default: begin
            end
          endcase
        end
      end
      S_PT_WR: begin
        ram_we    = 1'b1;
        ram_wdata = mode_q ? (ram_rdata | (8'd1 << bitsel_q))
                           : (ram_rdata & ~(8'd1 << bitsel_q));
        state_d   = S_IDLE;
      end
      S_RD_WAIT: begin
        out_valid_d = 1'b1;
        read_data_d = rd_zero_q ? BYTE_CLEAR : ram_rdata;
        state_d     = S_IDLE;
      end
      S_BLIT_RD: begin
        ram_raddr = pix_addr(cx_q, cy_q);
        if (on_screen(cx_q, cy_q)) begin
          paddr_d   = pix_addr(cx_q, cy_q);
          use_mem_d = 1'b1;
          state_d   = S_BLIT_WR;
        end else begin
          cx_d     = cx_nx;
          cy_d     = cy_nx;
          data_d   = data_q << 1;
          bitcnt_d = bitcnt_q + 3'd1;
          if (step_done) begin
            if (last_q) begin
              active_d = 1'b0;
            end
            state_d = S_IDLE;
          end
        end
      end
      S_BLIT_WR: begin
        ram_we   = 1'b1;
        buf_d    = merged;
        cx_d     = cx_nx;
        cy_d     = cy_nx;
        data_d   = data_q << 1;
        bitcnt_d = bitcnt_q + 3'd1;
        if (step_done) begin
          if (last_q) begin
            active_d = 1'b0;
          end
          state_d = S_IDLE;
        end else if (on_screen(cx_nx, cy_nx) && (pix_addr(cx_nx, cy_nx) == paddr_q)) begin
          use_mem_d = 1'b0;
        end else begin
          state_d = S_BLIT_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_SWEEP;
      sweep_addr_q <= '0;
      sweep_val_q  <= BYTE_CLEAR;
      cx_q         <= '0;
      cy_q         <= '0;
      oy_q         <= '0;
      height_q     <= '0;
      pol_q        <= 1'b0;
      active_q     <= 1'b0;
      bitcnt_q     <= '0;
      last_q       <= 1'b0;
      use_mem_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      sweep_addr_q <= sweep_addr_d;
      sweep_val_q  <= sweep_val_d;
      cx_q         <= cx_d;
      cy_q         <= cy_d;
      oy_q         <= oy_d;
      height_q     <= height_d;
      pol_q        <= pol_d;
      active_q     <= active_d;
      bitcnt_q     <= bitcnt_d;
      last_q       <= last_d;
      use_mem_q    <= use_mem_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q      <= data_d;
    mode_q      <= mode_d;
    bitsel_q    <= bitsel_d;
    paddr_q     <= paddr_d;
    buf_q       <= buf_d;
    rd_zero_q   <= rd_zero_d;
    read_data_q <= read_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = read_data_q;

  a_out_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_RD_WAIT))
    else $error("result raised without a read");

  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !ram_we)
    else $error("store written while idle");

  a_origin_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (32'(oy_q) < ROW_COUNT))
    else $error("active blit with off-screen origin row");

  a_blit_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BLIT_WR) |-> (ram_waddr == pix_addr(cx_q, cy_q)))
    else $error("blit write address does not match cursor");

endmodule

/* rtl/mpfb_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module mpfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
